FILE: src/immo_challenge_responder_xxtea16_macros.svh
// Assertion macros shared by the challenge responder RTL
`ifndef IMMO_CHALLENGE_RESPONDER_XXTEA16_MACROS_SVH
`define IMMO_CHALLENGE_RESPONDER_XXTEA16_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ICR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ICR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/icr_pkg.sv
// Types and constants of the 16-bit XXTEA challenge responder
package icr_pkg;

    localparam int WORD_W   = 16;
    localparam int ROUNDS   = 19;
    localparam int ROUND_W  = 5;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [1:0]         t_word_idx;
    typedef logic [ROUND_W-1:0] t_round;
    typedef logic [2:0]         t_reg_idx;
    typedef logic [63:0]        t_bytes8;

    localparam t_word DELTA        = 16'h79b9;
    localparam t_word DEC_SUM_INIT = t_word'(ROUNDS * 32'h79b9);
    localparam t_round ROUND_LAST  = t_round'(ROUNDS - 1);

    localparam t_word_idx WORD_FIRST = 2'd0;
    localparam t_word_idx WORD_LAST  = 2'd3;

    // register indexes on the configuration port
    localparam t_reg_idx REG_KEY_0     = 3'd0;
    localparam t_reg_idx REG_KEY_1     = 3'd1;
    localparam t_reg_idx REG_KEY_2     = 3'd2;
    localparam t_reg_idx REG_KEY_3     = 3'd3;
    localparam t_reg_idx REG_CHECK_HI  = 3'd4;
    localparam t_reg_idx REG_CHECK_LO  = 3'd5;

    localparam t_word KEY_0_RST    = 16'hDA3B;
    localparam t_word KEY_1_RST    = 16'h1511;
    localparam t_word KEY_2_RST    = 16'h2233;
    localparam t_word KEY_3_RST    = 16'hD7AB;
    localparam t_word CHECK_HI_RST = 16'hAABB;
    localparam t_word CHECK_LO_RST = 16'hCCDD;

endpackage

FILE: src/icr_channels.sv
// Handshake channel interfaces: challenge in, response out, register writes
interface icr_chal_if import icr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_bytes8 challenge_bytes;

    modport source (output valid, output challenge_bytes, input ready);
    modport sink   (input valid, input challenge_bytes, output ready);
endinterface

interface icr_resp_if import icr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_bytes8 response_bytes;
    logic    accepted;

    modport source (output valid, output response_bytes, output accepted, input ready);
    modport sink   (input valid, input response_bytes, input accepted, output ready);
endinterface

interface icr_cfg_if import icr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_word    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/icr_round_unit.sv
// Shared XXTEA word update: one mix and one add or subtract per cycle
module icr_round_unit import icr_pkg::*; (
    input  logic  i_dec,
    input  t_word i_cur,
    input  t_word i_z,
    input  t_word i_y,
    input  t_word i_sum,
    input  t_word i_key,
    output t_word o_word
);

    t_word mix_a;
    t_word mix_b;
    t_word mix;

    always_comb begin
        mix_a  = ((i_z >> 5) ^ (i_y << 2)) + ((i_y >> 3) ^ (i_z << 4));
        mix_b  = (i_sum ^ i_y) + (i_key ^ i_z);
        mix    = mix_a ^ mix_b;
        o_word = i_dec ? (i_cur - mix) : (i_cur + mix);
    end

endmodule

FILE: src/immo_challenge_responder_xxtea16.sv
// Immobilizer challenge responder: 16-bit-word XXTEA check and re-encrypt
//
// Channels: i_chal takes one 64-bit challenge (byte 0 in bits 63:56) per
// request; o_resp returns one 64-bit response with an accepted flag; i_cfg
// writes the four key words and two check words by index (always ready,
// indexes past the list are dropped). Configure only while idle.
// Sequence: one shared word-update unit does the 4 x 19 = 76 word updates of
// decryption, one per cycle, then the compare of the check words, then 76
// more for encryption when the check words match, then the hand-over. The
// block takes the next challenge only once it is back in idle after the
// hand-over, so it never works on two challenges at once.
// The response sits in an output register, so a new challenge is taken while
// the receiver stalls; a second finished response waits in the sequencer
// until the register frees up.
// Reset: key and check registers return to their defaults, the sequencer goes
// idle and any pending response is dropped.
`include "immo_challenge_responder_xxtea16_macros.svh"

module immo_challenge_responder_xxtea16 import icr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icr_chal_if.sink    i_chal,
    icr_resp_if.source  o_resp,
    icr_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_CHECK,
        S_ENC,
        S_FINISH
    } t_state;

    t_state    r_state;
    t_word     r_w0, r_w1, r_w2, r_w3;
    t_word     r_sum;
    t_word_idx r_p;
    t_round    r_round;
    logic      r_fin_acc;
    t_word     r_key [4];
    t_word     r_chk_hi;
    t_word     r_chk_lo;
    logic      r_out_valid;
    t_bytes8   r_resp;
    logic      r_acc;

    t_word     cur_w, z_w, y_w, key_w;
    t_word_idx key_idx;
    t_word     n_word;

    logic      chal_fire;
    logic      dec_at_start;
    logic      fin_go;
    logic      resp_reject;

    // current word, its left neighbor (z) and right neighbor (y)
    always_comb begin
        unique case (r_p)
            2'd0: begin cur_w = r_w0; z_w = r_w3; y_w = r_w1; end
            2'd1: begin cur_w = r_w1; z_w = r_w0; y_w = r_w2; end
            2'd2: begin cur_w = r_w2; z_w = r_w1; y_w = r_w3; end
            default: begin cur_w = r_w3; z_w = r_w2; y_w = r_w0; end
        endcase
        key_idx = r_p ^ r_sum[3:2];
        key_w   = r_key[key_idx];
    end

    icr_round_unit u_round (
        .i_dec  (r_state == S_DEC),
        .i_cur  (cur_w),
        .i_z    (z_w),
        .i_y    (y_w),
        .i_sum  (r_sum),
        .i_key  (key_w),
        .o_word (n_word)
    );

    assign i_chal.ready          = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_resp.valid          = r_out_valid;
    assign o_resp.response_bytes = r_resp;
    assign o_resp.accepted       = r_acc;

    assign chal_fire    = i_chal.valid && i_chal.ready;
    assign dec_at_start = (r_state == S_DEC) && (r_round == '0) && (r_p == WORD_LAST);
    assign fin_go       = (r_state == S_FINISH) && (!r_out_valid || o_resp.ready);
    assign resp_reject  = o_resp.valid && !o_resp.accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_key[0]    <= KEY_0_RST;
            r_key[1]    <= KEY_1_RST;
            r_key[2]    <= KEY_2_RST;
            r_key[3]    <= KEY_3_RST;
            r_chk_hi    <= CHECK_HI_RST;
            r_chk_lo    <= CHECK_LO_RST;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_KEY_0:    r_key[0] <= i_cfg.data;
                    REG_KEY_1:    r_key[1] <= i_cfg.data;
                    REG_KEY_2:    r_key[2] <= i_cfg.data;
                    REG_KEY_3:    r_key[3] <= i_cfg.data;
                    REG_CHECK_HI: r_chk_hi <= i_cfg.data;
                    REG_CHECK_LO: r_chk_lo <= i_cfg.data;
                    default: ;
                endcase
            end

            // in S_FINISH a taken response is always replaced below
            if (o_resp.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_DEC || r_state == S_ENC) begin
                unique case (r_p)
                    2'd0: r_w0 <= n_word;
                    2'd1: r_w1 <= n_word;
                    2'd2: r_w2 <= n_word;
                    default: r_w3 <= n_word;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_chal.valid) begin
                        r_w0    <= i_chal.challenge_bytes[63:48];
                        r_w1    <= i_chal.challenge_bytes[47:32];
                        r_w2    <= i_chal.challenge_bytes[31:16];
                        r_w3    <= i_chal.challenge_bytes[15:0];
                        r_sum   <= DEC_SUM_INIT;
                        r_p     <= WORD_LAST;
                        r_round <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    // decryption walks the words from last to first
                    if (r_p == WORD_FIRST) begin
                        r_sum <= r_sum - DELTA;
                        r_p   <= WORD_LAST;
                        if (r_round == ROUND_LAST) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end else begin
                        r_p <= r_p - 1'b1;
                    end
                end
                S_CHECK: begin
                    if (r_w2 == r_chk_hi && r_w3 == r_chk_lo) begin
                        r_w0    <= r_w2;
                        r_w1    <= r_w3;
                        r_w2    <= r_w0;
                        r_w3    <= r_w1;
                        r_sum   <= DELTA;
                        r_p     <= WORD_FIRST;
                        r_round <= '0;
                        r_state <= S_ENC;
                    end else begin
                        r_fin_acc <= 1'b0;
                        r_state   <= S_FINISH;
                    end
                end
                S_ENC: begin
                    if (r_p == WORD_LAST) begin
                        r_sum <= r_sum + DELTA;
                        r_p   <= WORD_FIRST;
                        if (r_round == ROUND_LAST) begin
                            r_fin_acc <= 1'b1;
                            r_state   <= S_FINISH;
                        end else begin
                            r_round <= r_round + 1'b1;
                        end
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
                default: begin
                    // S_FINISH: hand over once the output register is free
                    if (!r_out_valid || o_resp.ready) begin
                        r_out_valid <= 1'b1;
                        r_resp      <= r_fin_acc ? {r_w0, r_w1, r_w2, r_w3} : '1;
                        r_acc       <= r_fin_acc;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `ICR_ASSERT_SAME(a_reject_all_ones, resp_reject, &o_resp.response_bytes, "reject not all ones")
    `ICR_ASSERT_NEXT(a_accept_starts_dec, chal_fire, dec_at_start, "decryption did not start")
    `ICR_ASSERT_NEXT(a_finish_hands_over, fin_go, o_resp.valid && i_chal.ready, "no hand-over")

endmodule

FILE: tb/icr_response_checker.sv
// 16-bit XXTEA helper functions and the response scoreboard for the challenge responder
package icr_xxtea_tb_pkg;
    import icr_pkg::*;

    function automatic t_word mix16(t_word z, t_word y, t_word sum, t_word key);
        logic [31:0] zz, yy, a, b;
        zz = 32'(z);
        yy = 32'(y);
        a = ((zz >> 5) ^ (yy << 2)) + ((yy >> 3) ^ (zz << 4));
        b = (32'(sum) ^ yy) + (32'(key) ^ zz);
        return t_word'(a ^ b);
    endfunction

    // blocks and keys are packed as four words, word 0 in bits 63:48
    function automatic t_bytes8 xxtea16_decipher(t_bytes8 blk, t_bytes8 key);
        t_word     v[4];
        t_word     k[4];
        t_word     sum, y, z;
        logic [1:0] e;
        int        i, r, p;
        for (i = 0; i < 4; i++) begin
            v[i] = blk[63-16*i -: 16];
            k[i] = key[63-16*i -: 16];
        end
        sum = t_word'(ROUNDS * DELTA);
        y = v[0];
        for (r = 0; r < ROUNDS; r++) begin
            e = sum[3:2];
            for (p = 3; p > 0; p--) begin
                z = v[p-1];
                v[p] = v[p] - mix16(z, y, sum, k[p[1:0] ^ e]);
                y = v[p];
            end
            z = v[3];
            v[0] = v[0] - mix16(z, y, sum, k[e]);
            y = v[0];
            sum = sum - DELTA;
        end
        return {v[0], v[1], v[2], v[3]};
    endfunction

    function automatic t_bytes8 xxtea16_encipher(t_bytes8 blk, t_bytes8 key);
        t_word     v[4];
        t_word     k[4];
        t_word     sum, y, z;
        logic [1:0] e;
        int        i, r, p;
        for (i = 0; i < 4; i++) begin
            v[i] = blk[63-16*i -: 16];
            k[i] = key[63-16*i -: 16];
        end
        sum = '0;
        z = v[3];
        for (r = 0; r < ROUNDS; r++) begin
            sum = sum + DELTA;
            e = sum[3:2];
            for (p = 0; p < 3; p++) begin
                y = v[p+1];
                v[p] = v[p] + mix16(z, y, sum, k[p[1:0] ^ e]);
                z = v[p];
            end
            y = v[0];
            v[3] = v[3] + mix16(z, y, sum, k[WORD_LAST ^ e]);
            z = v[3];
        end
        return {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

module icr_response_checker import icr_pkg::*; import icr_xxtea_tb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    icr_chal_if  i_chal,
    icr_resp_if  i_resp,
    icr_cfg_if   i_cfg,
    input  logic i_final,
    output int   o_fail_cnt,
    output int   o_pending,
    output int   o_granted_cnt,
    output int   o_denied_cnt
);

    typedef struct {
        t_bytes8 challenge;
        t_bytes8 response_bytes;
        logic    accepted;
    } t_answer;

    t_bytes8 key_copy;
    t_word   check_hi_copy;
    t_word   check_lo_copy;
    t_answer answers_due[$];
    logic    final_seen;

    function automatic t_answer answer_challenge(t_bytes8 c);
        t_answer a;
        t_bytes8 plain;
        a.challenge = c;
        plain = xxtea16_decipher(c, key_copy);
        if (plain[31:16] == check_hi_copy && plain[15:0] == check_lo_copy) begin
            // words go back out as w2,w3,w0,w1
            a.response_bytes = xxtea16_encipher({plain[31:0], plain[63:32]}, key_copy);
            a.accepted = 1'b1;
        end else begin
            a.response_bytes = '1;
            a.accepted = 1'b0;
        end
        return a;
    endfunction

    initial begin
        o_fail_cnt = 0;
        o_pending = 0;
        o_granted_cnt = 0;
        o_denied_cnt = 0;
        final_seen = 1'b0;
        key_copy = {KEY_0_RST, KEY_1_RST, KEY_2_RST, KEY_3_RST};
        check_hi_copy = CHECK_HI_RST;
        check_lo_copy = CHECK_LO_RST;
    end

    always @(posedge i_clk) begin
        t_answer due;
        if (!i_rst_n) begin
            key_copy = {KEY_0_RST, KEY_1_RST, KEY_2_RST, KEY_3_RST};
            check_hi_copy = CHECK_HI_RST;
            check_lo_copy = CHECK_LO_RST;
            answers_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_KEY_0:    key_copy[63:48] = i_cfg.data;
                    REG_KEY_1:    key_copy[47:32] = i_cfg.data;
                    REG_KEY_2:    key_copy[31:16] = i_cfg.data;
                    REG_KEY_3:    key_copy[15:0]  = i_cfg.data;
                    REG_CHECK_HI: check_hi_copy = i_cfg.data;
                    REG_CHECK_LO: check_lo_copy = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_resp.valid && i_resp.ready) begin
                if (i_resp.accepted)
                    o_granted_cnt++;
                else
                    o_denied_cnt++;
                if (answers_due.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("unexpected response %h accepted %0b, no request outstanding",
                                 i_resp.response_bytes, i_resp.accepted);
                end else begin
                    due = answers_due.pop_front();
                    if (i_resp.response_bytes !== due.response_bytes
                        || i_resp.accepted !== due.accepted) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10)
                            $display("challenge %h: expected %h accepted %0b, got %h accepted %0b",
                                     due.challenge, due.response_bytes, due.accepted,
                                     i_resp.response_bytes, i_resp.accepted);
                    end
                end
            end
            if (i_chal.valid && i_chal.ready)
                answers_due.push_back(answer_challenge(i_chal.challenge_bytes));
            if (i_final && !final_seen) begin
                final_seen = 1'b1;
                if (answers_due.size() != 0) begin
                    o_fail_cnt += answers_due.size();
                    $display("%0d responses never arrived", answers_due.size());
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

FILE: tb/immo_challenge_responder_xxtea16_test.sv
// Stimulus and verdict for the 16-bit XXTEA immobilizer challenge responder
module immo_challenge_responder_xxtea16_test;
    import icr_pkg::*;
    import icr_xxtea_tb_pkg::*;

    localparam int ITEMS_PER_SET  = 240;
    localparam int NUM_SETS       = 5;
    localparam int HOLD_CYCLES    = 800;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    // indexes past the register list, dropped by the block
    localparam t_reg_idx REG_NONE_6 = 3'd6;
    localparam t_reg_idx REG_NONE_7 = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic test_final = 1'b0;

    int send_gap_pct = 16;
    int recv_gap_pct = 69;
    int pressure_reqs = 0;
    int fail_cnt, pending_cnt, granted_cnt, denied_cnt;

    t_bytes8 key_cur = {KEY_0_RST, KEY_1_RST, KEY_2_RST, KEY_3_RST};
    t_word   check_hi_cur = CHECK_HI_RST;
    t_word   check_lo_cur = CHECK_LO_RST;

    icr_chal_if chal_bus ();
    icr_resp_if resp_bus ();
    icr_cfg_if  cfg_bus ();

    immo_challenge_responder_xxtea16 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chal  (chal_bus),
        .o_resp  (resp_bus),
        .i_cfg   (cfg_bus)
    );

    icr_response_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chal        (chal_bus),
        .i_resp        (resp_bus),
        .i_cfg         (cfg_bus),
        .i_final       (test_final),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending_cnt),
        .o_granted_cnt (granted_cnt),
        .o_denied_cnt  (denied_cnt)
    );

    always #5 i_clk = ~i_clk;

    // builds a challenge that decrypts to x0,x1,hi,lo under the current key
    function automatic t_bytes8 seal(t_word x0, t_word x1, t_word hi, t_word lo);
        return xxtea16_encipher({x0, x1, hi, lo}, key_cur);
    endfunction

    function automatic t_bytes8 pick_challenge();
        int    sel;
        t_word nz;
        sel = $urandom_range(99);
        nz = t_word'($urandom_range(65535, 1));
        if (sel < 60)
            return seal(t_word'($urandom), t_word'($urandom), check_hi_cur, check_lo_cur);
        else if (sel < 70)
            return seal(t_word'($urandom), t_word'($urandom), check_hi_cur ^ nz, check_lo_cur);
        else if (sel < 80)
            return seal(t_word'($urandom), t_word'($urandom), check_hi_cur, check_lo_cur ^ nz);
        else
            return {$urandom, $urandom};
    endfunction

    task automatic send_challenge(input t_bytes8 bytes);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            chal_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        chal_bus.valid <= 1'b1;
        chal_bus.challenge_bytes <= bytes;
        @(posedge i_clk);
        while (!(chal_bus.valid && chal_bus.ready))
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input t_word value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge i_clk);
        while (!(cfg_bus.valid && cfg_bus.ready))
            @(posedge i_clk);
    endtask

    task automatic program_regs(input t_bytes8 key, input t_word hi, input t_word lo,
                                input bit with_spare);
        int i;
        for (i = 0; i < 4; i++)
            write_reg(t_reg_idx'(REG_KEY_0 + i), key[63-16*i -: 16]);
        write_reg(REG_CHECK_HI, hi);
        write_reg(REG_CHECK_LO, lo);
        if (with_spare) begin
            write_reg(REG_NONE_6, t_word'($urandom));
            write_reg(REG_NONE_7, 16'hFFFF);
        end
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        key_cur = key;
        check_hi_cur = hi;
        check_lo_cur = lo;
    endtask

    // drop the request line and wait for every response plus some slack
    task automatic settle();
        @(negedge i_clk);
        chal_bus.valid <= 1'b0;
        while (pending_cnt != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_challenge(64'h0);
        send_challenge('1);
        send_challenge(64'h5555_5555_5555_5555);
        send_challenge(64'hAAAA_AAAA_AAAA_AAAA);
        send_challenge(seal(16'h0000, 16'h0000, check_hi_cur, check_lo_cur));
        send_challenge(seal(16'hFFFF, 16'hFFFF, check_hi_cur, check_lo_cur));
        send_challenge(seal(16'h8000, 16'h0001, check_hi_cur, check_lo_cur));
        // one check word right, the other off by a single bit
        send_challenge(seal(16'h1234, 16'h5678, check_hi_cur, check_lo_cur ^ 16'h0001));
        send_challenge(seal(16'h1234, 16'h5678, check_hi_cur ^ 16'h8000, check_lo_cur));
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        resp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_reqs != served) begin
                served = pressure_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                resp_bus.ready <= 1'b0;
            end else begin
                resp_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((chal_bus.valid && chal_bus.ready) || (resp_bus.valid && resp_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int set_no;
        int n;
        int rnd_idx;
        t_bytes8 key;
        t_word hi, lo;
        chal_bus.valid = 1'b0;
        chal_bus.challenge_bytes = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_KEY_0;
        cfg_bus.data = '0;
        rnd_idx = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        settle();

        for (set_no = 0; set_no < NUM_SETS; set_no++) begin
            case (set_no)
                0: begin
                    key = '0;
                    hi = '0;
                    lo = '0;
                end
                1: begin
                    key = '1;
                    hi = '1;
                    lo = '1;
                end
                default: begin
                    key = {$urandom, $urandom};
                    hi = t_word'($urandom);
                    lo = t_word'($urandom);
                end
            endcase
            program_regs(key, hi, lo, set_no == NUM_SETS - 1);
            if (set_no == 1)
                run_directed();
            for (n = 0; n < ITEMS_PER_SET; n++) begin
                case (rnd_idx * 3 / (NUM_SETS * ITEMS_PER_SET))
                    0: begin
                        send_gap_pct = 16;
                        recv_gap_pct = 69;
                    end
                    1: begin
                        send_gap_pct = 69;
                        recv_gap_pct = 16;
                    end
                    default: begin
                        send_gap_pct = 0;
                        recv_gap_pct = 0;
                    end
                endcase
                // stall the output long enough to back the block up
                if (set_no == 2 && n == ITEMS_PER_SET / 2)
                    pressure_reqs++;
                send_challenge(pick_challenge());
                rnd_idx++;
            end
            settle();
        end

        @(negedge i_clk);
        test_final <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        $display("checked %0d responses (%0d granted, %0d denied) over %0d register settings,",
                 granted_cnt + denied_cnt, granted_cnt, denied_cnt, NUM_SETS + 1);
        $display("with sender and receiver stalls and one long output hold-off");
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures", fail_cnt);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/icr_pkg.sv
src/icr_channels.sv
src/icr_round_unit.sv
src/immo_challenge_responder_xxtea16.sv
tb/icr_response_checker.sv
tb/immo_challenge_responder_xxtea16_test.sv
